[hdl/assert_macros.svh]
// Assertion helper macros for the RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked at every clock edge, reset included.
`define ASSERT_RESET(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/hft_pkg.sv]
// Types and codes for the handle tagged FIFO.
// No dependencies; imported by hft_ctrl, hft_store, handle_tagged_fifo and tb.
package hft_pkg;

  localparam int DATA_W   = 32;
  localparam int TICKET_W = 8;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  typedef logic [DATA_W-1:0]   data_t;
  typedef logic [TICKET_W-1:0] ticket_t;
  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  // Command codes
  localparam cmd_t CMD_PUSH   = 2'd0;
  localparam cmd_t CMD_POP    = 2'd1;
  localparam cmd_t CMD_DELETE = 2'd2;

  // Result status codes
  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_FULL       = 3'd1;
  localparam status_t ST_EMPTY      = 3'd2;
  localparam status_t ST_DROPPED    = 3'd3;
  localparam status_t ST_NOT_QUEUED = 3'd4;

  // Command item
  typedef struct packed {
    cmd_t    cmd;
    data_t   push_value;
    ticket_t ticket;
  } req_t;

  // Result item
  typedef struct packed {
    logic    ok;
    status_t status;
    ticket_t new_ticket;
    data_t   pop_value;
  } rsp_t;

  // Memory access requests; the slot is the low bits of the ticket
  typedef struct packed {
    logic    wr_en;
    ticket_t wr_tk;
    data_t   wr_data;
    logic    cx_en;
    ticket_t cx_tk;
    logic    cx_set;
    logic    rd_en;
    ticket_t rd_tk;
  } mem_req_t;

  // Result held for the cycle after a command
  typedef struct packed {
    logic    strobe;
    logic    pop_read;
    logic    ok;
    status_t status;
    ticket_t new_ticket;
  } pend_t;

endpackage

[hdl/hft_store.sv]
// Slot storage: data words and cancel flags, with a registered read.
// Depends on hft_pkg.
module hft_store import hft_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  mem_req_t mem_req,
  output data_t    rd_value,
  output logic     rd_cancel
);

  localparam int SLOT_W = $clog2(DEPTH);

  data_t value_mem  [DEPTH];
  logic  cancel_mem [DEPTH];

  // Data word memory
  always_ff @(posedge clk) begin
    if (mem_req.wr_en) begin
      value_mem[mem_req.wr_tk[SLOT_W-1:0]] <= mem_req.wr_data;
    end
    if (mem_req.rd_en) begin
      rd_value <= value_mem[mem_req.rd_tk[SLOT_W-1:0]];
    end
  end

  // Cancel flag memory: cleared by push, set by delete
  always_ff @(posedge clk) begin
    if (mem_req.cx_en) begin
      cancel_mem[mem_req.cx_tk[SLOT_W-1:0]] <= mem_req.cx_set;
    end
    if (mem_req.rd_en) begin
      rd_cancel <= cancel_mem[mem_req.rd_tk[SLOT_W-1:0]];
    end
  end

endmodule

[hdl/hft_ctrl.sv]
// Queue pointers, ticket counters and command decode.
// Depends on hft_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hft_ctrl import hft_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  req_t     req,
  output mem_req_t mem_req,
  output pend_t    pend
);

  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam int CMP_W = TICKET_W + 1;

  logic [OCC_W-1:0] occupancy, occupancy_next;
  ticket_t          oldest_ticket, oldest_ticket_next;
  ticket_t          next_ticket, next_ticket_next;
  pend_t            pend_next;
  ticket_t          span;
  logic             queued;
  logic             full;
  logic             empty;

  // Window test for delete: distance from the oldest ticket
  assign span   = req.ticket - oldest_ticket;
  assign queued = {1'b0, span} < CMP_W'(occupancy);
  assign full   = occupancy == OCC_W'(DEPTH);
  assign empty  = occupancy == '0;

  // Command decode
  always_comb begin
    occupancy_next     = occupancy;
    oldest_ticket_next = oldest_ticket;
    next_ticket_next   = next_ticket;
    mem_req            = '0;
    mem_req.wr_tk      = next_ticket;
    mem_req.wr_data    = req.push_value;
    mem_req.rd_tk      = oldest_ticket;
    pend_next          = '0;
    pend_next.strobe   = accept;
    pend_next.status   = ST_NOT_QUEUED;
    unique case (req.cmd)
      CMD_PUSH: begin
        if (full) begin
          pend_next.status = ST_FULL;
        end else begin
          mem_req.wr_en        = accept;
          mem_req.cx_en        = accept;
          mem_req.cx_tk        = next_ticket;
          mem_req.cx_set       = 1'b0;
          pend_next.ok         = 1'b1;
          pend_next.status     = ST_OK;
          pend_next.new_ticket = next_ticket;
          next_ticket_next     = next_ticket + 1'b1;
          occupancy_next       = occupancy + 1'b1;
        end
      end
      CMD_POP: begin
        if (empty) begin
          pend_next.status = ST_EMPTY;
        end else begin
          // ok and status come from the cancel flag read back
          mem_req.rd_en      = accept;
          pend_next.pop_read = 1'b1;
          oldest_ticket_next = oldest_ticket + 1'b1;
          occupancy_next     = occupancy - 1'b1;
        end
      end
      CMD_DELETE: begin
        if (queued) begin
          mem_req.cx_en    = accept;
          mem_req.cx_tk    = req.ticket;
          mem_req.cx_set   = 1'b1;
          pend_next.ok     = 1'b1;
          pend_next.status = ST_OK;
        end
      end
      default: begin
        pend_next.status = ST_NOT_QUEUED;
      end
    endcase
  end

  // Control state and result register; the payload needs no reset
  always_ff @(posedge clk) begin
    pend.pop_read   <= pend_next.pop_read;
    pend.ok         <= pend_next.ok;
    pend.status     <= pend_next.status;
    pend.new_ticket <= pend_next.new_ticket;
    if (rst) begin
      occupancy     <= '0;
      oldest_ticket <= '0;
      next_ticket   <= '0;
      pend.strobe   <= 1'b0;
    end else begin
      pend.strobe <= pend_next.strobe;
      if (accept) begin
        occupancy     <= occupancy_next;
        oldest_ticket <= oldest_ticket_next;
        next_ticket   <= next_ticket_next;
      end
    end
  end

  `ASSERT_ALWAYS(a_occ_bound, clk, rst, occupancy <= OCC_W'(DEPTH), "occupancy above depth")
  `ASSERT_ALWAYS(a_ticket_span, clk, rst, ticket_t'(next_ticket - oldest_ticket) == ticket_t'(occupancy), "ticket span differs from occupancy")
  `ASSERT_ALWAYS(a_strobe_follows, clk, rst, pend.strobe |-> $past(accept), "result without a command")
  `ASSERT_RESET(a_reset_quiet, clk, rst |=> !pend.strobe, "result strobe after reset")

endmodule

[hdl/handle_tagged_fifo.sv]
// Handle tagged FIFO: every command gives its result in the cycle after it is taken.
// A command may be issued in every cycle; busy is never raised, so throughput is
// one command per cycle.
// Synchronous reset empties the queue and zeroes both ticket counters; slot
// contents are not cleared, only written slots are ever read.
// Results appear on done for one cycle; the receiver cannot stall them.
module handle_tagged_fifo import hft_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  mem_req_t mem_req;
  pend_t    pend;
  data_t    rd_value;
  logic     rd_cancel;
  logic     accept;

  // Every command completes without a stall, so the block is always ready
  assign busy   = 1'b0;
  assign accept = start && !busy;

  hft_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .req     (req),
    .mem_req (mem_req),
    .pend    (pend)
  );

  hft_store #(.DEPTH(DEPTH)) u_store (
    .clk       (clk),
    .mem_req   (mem_req),
    .rd_value  (rd_value),
    .rd_cancel (rd_cancel)
  );

  // Result merge: a pop takes ok and status from the cancel flag
  always_comb begin
    done           = pend.strobe;
    rsp.new_ticket = pend.new_ticket;
    if (pend.pop_read) begin
      rsp.ok        = !rd_cancel;
      rsp.status    = rd_cancel ? ST_DROPPED : ST_OK;
      rsp.pop_value = rd_cancel ? '0 : rd_value;
    end else begin
      rsp.ok        = pend.ok;
      rsp.status    = pend.status;
      rsp.pop_value = '0;
    end
  end

endmodule

[dv/tb.sv]
// Self-checking testbench for handle_tagged_fifo: directed and random command items,
// with results predicted by a scoreboard class and checked as they appear.
// Depends on hft_pkg and the handle_tagged_fifo RTL.
module tb;
  import hft_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int   DEPTH      = 16;
  localparam cmd_t CMD_UNUSED = 2'd3;

  // Tracks queue contents and tickets, predicts each result and checks it
  class hft_scoreboard;
    data_t       slot_data [DEPTH];
    bit          slot_gone [DEPTH];
    int unsigned rd_slot;
    int unsigned wr_slot;
    int unsigned fill;
    ticket_t     oldest_tk;
    ticket_t     next_tk;
    rsp_t        rsp_due[$];
    int          mismatches;

    function new();
      rd_slot    = 0;
      wr_slot    = 0;
      fill       = 0;
      oldest_tk  = '0;
      next_tk    = '0;
      mismatches = 0;
    endfunction

    // Apply an accepted command item and queue the result it must give
    function void note_cmd(input req_t r);
      rsp_t    e;
      ticket_t gap;
      e = '0;
      case (r.cmd)
        CMD_PUSH: begin
          if (fill >= DEPTH) begin
            e.status = ST_FULL;
          end else begin
            slot_data[wr_slot] = r.push_value;
            slot_gone[wr_slot] = 1'b0;
            e.new_ticket = next_tk;
            next_tk      = next_tk + 1'b1;
            wr_slot      = (wr_slot == DEPTH - 1) ? 0 : wr_slot + 1;
            fill++;
            e.ok     = 1'b1;
            e.status = ST_OK;
          end
        end
        CMD_POP: begin
          if (fill == 0) begin
            e.status = ST_EMPTY;
          end else begin
            if (slot_gone[rd_slot]) begin
              e.status = ST_DROPPED;
            end else begin
              e.ok        = 1'b1;
              e.status    = ST_OK;
              e.pop_value = slot_data[rd_slot];
            end
            rd_slot   = (rd_slot == DEPTH - 1) ? 0 : rd_slot + 1;
            oldest_tk = oldest_tk + 1'b1;
            fill--;
          end
        end
        CMD_DELETE: begin
          // ticket is queued when it lies within the window starting at the oldest
          gap = r.ticket - oldest_tk;
          if (gap < fill) begin
            slot_gone[r.ticket % DEPTH] = 1'b1;
            e.ok     = 1'b1;
            e.status = ST_OK;
          end else begin
            e.status = ST_NOT_QUEUED;
          end
        end
        default: begin
          e.status = ST_NOT_QUEUED;
        end
      endcase
      rsp_due.push_back(e);
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    // Compare a result against the oldest outstanding prediction
    function void check_rsp(input rsp_t got);
      rsp_t want;
      if (rsp_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        mismatches++;
      end else begin
        want = rsp_due.pop_front();
        compare_field("ok", want.ok, got.ok);
        compare_field("status", want.status, got.status);
        compare_field("new_ticket", want.new_ticket, got.new_ticket);
        compare_field("pop_value", want.pop_value, got.pop_value);
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req   = '0;
  logic done;
  rsp_t rsp;

  hft_scoreboard sb = new();

  handle_tagged_fifo #(.DEPTH(DEPTH)) dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .rsp  (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && done) sb.check_rsp(rsp);
  end

  // Present one item and hold it until taken
  task automatic issue(input req_t r);
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy === 1'b1);
    sb.note_cmd(r);
  endtask

  // Idle the sender for a random number of cycles, pct percent per cycle
  task automatic rest(input int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic directed_items();
    req_t r;
    r = '0;
    r.cmd = CMD_POP;
    issue(r);                        // pop when empty
    r.cmd = CMD_UNUSED;
    r.ticket = 8'hff;
    issue(r);
    // fill to the brim with edge data patterns, then one push too many
    for (int i = 0; i <= DEPTH; i++) begin
      r.cmd    = CMD_PUSH;
      r.ticket = ticket_t'($urandom_range(255));
      case (i)
        0:       r.push_value = '0;
        1:       r.push_value = '1;
        2:       r.push_value = 32'haaaa_aaaa;
        3:       r.push_value = 32'h5555_5555;
        default: r.push_value = $urandom;
      endcase
      issue(r);
    end
    r.cmd = CMD_DELETE;
    r.ticket = 8'd2;
    issue(r);
    issue(r);                        // cancelling twice still succeeds
    r.ticket = 8'd200;
    issue(r);                        // outside the queued window
    r.cmd = CMD_POP;
    repeat (3) issue(r);             // third pop drops the cancelled entry
  endtask

  // Random items; push bias swings per block of 32 so the queue fills and drains
  task automatic random_items(input int n, input int pct);
    req_t r;
    int   roll;
    int   push_w;
    push_w = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 32 == 0) push_w = ($urandom_range(1) == 0) ? 62 : 24;
      r.push_value = $urandom;
      r.ticket     = ticket_t'($urandom_range(255));
      roll         = $urandom_range(99);
      if (roll < 2) begin
        r.cmd = CMD_UNUSED;
      end else if (roll < push_w) begin
        r.cmd = CMD_PUSH;
      end else if (roll < 80) begin
        r.cmd = CMD_POP;
      end else begin
        r.cmd = CMD_DELETE;
        // mostly live tickets; sometimes just past either end of the window
        roll = $urandom_range(7);
        if (sb.fill != 0 && roll < 5)
          r.ticket = sb.oldest_tk + ticket_t'($urandom_range(sb.fill - 1));
        else if (roll == 5)
          r.ticket = sb.oldest_tk + ticket_t'(sb.fill);
        else if (roll == 6)
          r.ticket = sb.oldest_tk - 1'b1;
      end
      rest(pct);
      issue(r);
    end
  endtask

  initial begin
    int guard;
    guard = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_items();
    random_items(384, 0);
    random_items(384, 68);
    random_items(384, 26);
    random_items(384, 0);

    @(negedge clk);
    start <= 1'b0;
    while (sb.rsp_due.size() != 0 && guard < 50) begin
      @(posedge clk);
      guard++;
    end
    repeat (5) @(posedge clk);
    if (sb.rsp_due.size() != 0) begin
      $display("%0t: %0d results missing, expected %p, actual none", $time,
               sb.rsp_due.size(), sb.rsp_due[0]);
      sb.mismatches++;
    end

    if (sb.mismatches == 0) begin
      $display("[handle_tagged_fifo] OK");
    end else begin
      $display("[handle_tagged_fifo] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("[handle_tagged_fifo] ERROR");
    $finish;
  end

endmodule
